FILE: design/ewt_pkg.sv
// Shared types and constants for the extrude wall triangulator.
// Depends on nothing; every other design file imports it.
package ewt_pkg;

    // Fixed field widths
    localparam int COORD_WIDTH = 24;
    localparam int TRIG_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // Edge queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [TRIG_W-1:0]      t_trig;
    typedef logic [2:0]                    t_corner;

    localparam t_corner LAST_CORNER   = 3'd5;
    localparam t_trig   TRIG_ONE      = 16'sd16384;
    localparam t_trig   TRIG_ZERO     = 16'sd0;
    localparam t_coord  Z_LOWER_RESET = 24'sd0;
    localparam t_coord  Z_UPPER_RESET = 24'sd256;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_LOWER = 3'd0,
        CFG_SIN_LOWER = 3'd1,
        CFG_COS_UPPER = 3'd2,
        CFG_SIN_UPPER = 3'd3,
        CFG_Z_LOWER   = 3'd4,
        CFG_Z_UPPER   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_trig  cos_lower;
        t_trig  sin_lower;
        t_trig  cos_upper;
        t_trig  sin_upper;
        t_coord z_lower;
        t_coord z_upper;
    } t_cfg;

    // Input and output payloads
    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        logic   hole;
        logic   path_start;
    } t_point;

    typedef struct packed {
        t_coord  vertex_x;
        t_coord  vertex_y;
        t_coord  vertex_z;
        t_corner corner;
        logic    last;
    } t_vertex;

    // One rotated point
    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_xy;

    // One edge ready for emission: previous (k) and current (j) point,
    // lower and upper copies
    typedef struct packed {
        t_xy  kl;
        t_xy  ku;
        t_xy  jl;
        t_xy  ju;
        logic inner;
        logic swap;
    } t_edge;

    // Front sequencer states
    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MUL_L,
        FS_MUL_U,
        FS_SUM_U,
        FS_SQR,
        FS_CMP
    } t_front_state;

endpackage

FILE: design/ewt_front.sv
// Front end: accepts path points, rotates them on a shared multiplier bank,
// picks the quad diagonal and pushes one edge record. Uses ewt_pkg.
module ewt_front
    import ewt_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_point i_in_point,
    input  t_cfg   i_cfg,
    output logic   o_push_valid,
    input  logic   i_push_ready,
    output t_edge  o_push_edge
);

    localparam int MUL_W  = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SAT_MAX  =
        {{(SUM_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN  = ~SAT_MAX;

    t_front_state r_state, n_state;

    t_coord r_x, r_y;
    logic   r_inner, r_start, r_have_prev;
    t_xy    r_jl, r_ju, r_kl, r_ku;

    logic signed [MUL_W-1:0]  op_a [4];
    logic signed [MUL_W-1:0]  op_b [4];
    logic signed [PROD_W-1:0] r_prod [4];

    logic signed [SUM_W-1:0] sum_x, sum_y, rnd_x, rnd_y, sq_a, sq_b;
    t_xy  rot;
    logic in_accept, push_accept, swap;

    function automatic t_coord sat_coord(input logic signed [SUM_W-1:0] v);
        if (v > SAT_MAX) begin
            return SAT_MAX[COORD_WIDTH-1:0];
        end else if (v < SAT_MIN) begin
            return SAT_MIN[COORD_WIDTH-1:0];
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    assign in_accept   = i_in_valid && o_in_ready;
    assign push_accept = o_push_valid && i_push_ready;

    // Rotation: x' = x*c + y*s, y' = y*c - x*s, round half up, saturate
    always_comb begin
        sum_x = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]);
        sum_y = SUM_W'(r_prod[2]) - SUM_W'(r_prod[3]);
        rnd_x = (sum_x + RND_BIAS) >>> TRIG_FRAC_BITS;
        rnd_y = (sum_y + RND_BIAS) >>> TRIG_FRAC_BITS;
        rot.x = sat_coord(rnd_x);
        rot.y = sat_coord(rnd_y);
    end

    // Squared diagonal lengths, exact
    always_comb begin
        sq_a = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]);
        sq_b = SUM_W'(r_prod[2]) + SUM_W'(r_prod[3]);
        swap = sq_a > sq_b;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE:  if (in_accept) n_state = FS_MUL_L;
            FS_MUL_L: n_state = FS_MUL_U;
            FS_MUL_U: n_state = FS_SUM_U;
            FS_SUM_U: n_state = r_start ? FS_IDLE : FS_SQR;
            FS_SQR:   n_state = FS_CMP;
            FS_CMP:   if (i_push_ready) n_state = FS_IDLE;
            default:  n_state = FS_IDLE;
        endcase
    end

    // Outputs and multiplier operand selection
    always_comb begin
        o_in_ready   = 1'b0;
        o_push_valid = 1'b0;
        for (int i = 0; i < 4; i++) begin
            op_a[i] = '0;
            op_b[i] = '0;
        end
        case (r_state)
            FS_IDLE: begin
                o_in_ready = 1'b1;
            end
            FS_MUL_L: begin
                op_a[0] = MUL_W'(r_x);  op_b[0] = MUL_W'(i_cfg.cos_lower);
                op_a[1] = MUL_W'(r_y);  op_b[1] = MUL_W'(i_cfg.sin_lower);
                op_a[2] = MUL_W'(r_y);  op_b[2] = MUL_W'(i_cfg.cos_lower);
                op_a[3] = MUL_W'(r_x);  op_b[3] = MUL_W'(i_cfg.sin_lower);
            end
            FS_MUL_U: begin
                op_a[0] = MUL_W'(r_x);  op_b[0] = MUL_W'(i_cfg.cos_upper);
                op_a[1] = MUL_W'(r_y);  op_b[1] = MUL_W'(i_cfg.sin_upper);
                op_a[2] = MUL_W'(r_y);  op_b[2] = MUL_W'(i_cfg.cos_upper);
                op_a[3] = MUL_W'(r_x);  op_b[3] = MUL_W'(i_cfg.sin_upper);
            end
            FS_SQR, FS_CMP: begin
                // diagonals jL-kU and jU-kL, each component squared; kept
                // on the bank while the push waits so the squares hold
                op_a[0] = MUL_W'(r_jl.x) - MUL_W'(r_ku.x);
                op_a[1] = MUL_W'(r_jl.y) - MUL_W'(r_ku.y);
                op_a[2] = MUL_W'(r_ju.x) - MUL_W'(r_kl.x);
                op_a[3] = MUL_W'(r_ju.y) - MUL_W'(r_kl.y);
                for (int i = 0; i < 4; i++) begin
                    op_b[i] = op_a[i];
                end
                o_push_valid = (r_state == FS_CMP);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_push_edge.kl    = r_kl;
        o_push_edge.ku    = r_ku;
        o_push_edge.jl    = r_jl;
        o_push_edge.ju    = r_ju;
        o_push_edge.inner = r_inner;
        o_push_edge.swap  = swap;
    end

    // Multiplier bank, registered products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_prod[i] <= op_a[i] * op_b[i];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FS_IDLE;
            r_have_prev <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == FS_SUM_U && r_start) begin
                r_have_prev <= 1'b1;
            end
        end
    end

    // Point and rotated copies
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x     <= i_in_point.point_x;
            r_y     <= i_in_point.point_y;
            r_inner <= i_in_point.hole;
            r_start <= i_in_point.path_start || !r_have_prev;
        end
        if (r_state == FS_MUL_U) begin
            r_jl <= rot;
        end
        if (r_state == FS_SUM_U) begin
            r_ju <= rot;
            if (r_start) begin
                r_kl <= r_jl;
                r_ku <= rot;
            end
        end
        if (push_accept) begin
            r_kl <= r_jl;
            r_ku <= r_ju;
        end
    end

    // Once a point is stored, a previous point exists for good
    a_prev_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_prev |=> r_have_prev)
        else $error("previous-point flag dropped");

    // An edge is only pushed when a previous point exists
    a_push_has_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push_valid |-> r_have_prev)
        else $error("edge pushed without previous point");

    // A path start returns to idle and leaves a stored point
    a_start_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_SUM_U && r_start) |=> (r_state == FS_IDLE && r_have_prev))
        else $error("path start did not complete");

endmodule

FILE: design/ewt_queue.sv
// Short edge queue between front end and vertex emitter.
// Uses ewt_pkg for the edge record and depth.
module ewt_queue
    import ewt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_edge i_push_edge,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_edge o_pop_edge
);

    t_edge             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push, pop;

    assign o_push_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_edge   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_edge;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: design/ewt_back.sv
// Back end: walks one edge record through its six triangle vertices into
// the output register. Uses ewt_pkg.
module ewt_back
    import ewt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_pop_valid,
    output logic    o_pop_ready,
    input  t_edge   i_pop_edge,
    input  t_cfg    i_cfg,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_vertex o_out_vertex
);

    typedef struct packed {
        logic use_j;
        logic upper;
    } t_pick;

    t_corner r_corner;
    logic    r_out_valid;
    t_vertex r_vtx, vtx;
    t_pick   pick;
    t_xy     src;
    logic    load;

    // Vertex source for a corner; outer paths reverse each triangle
    function automatic t_pick pick_corner(input t_corner c, input logic sw,
                                          input logic inner);
        t_corner s;
        t_pick   p;
        s = c;
        if (!inner) begin
            case (c)
                3'd0:    s = 3'd2;
                3'd2:    s = 3'd0;
                3'd3:    s = 3'd5;
                3'd5:    s = 3'd3;
                default: s = c;
            endcase
        end
        p = '0;
        if (sw) begin
            // (kL, jL, jU) then (kU, kL, jU)
            case (s)
                3'd0:    p = '{use_j: 1'b0, upper: 1'b0};
                3'd1:    p = '{use_j: 1'b1, upper: 1'b0};
                3'd2:    p = '{use_j: 1'b1, upper: 1'b1};
                3'd3:    p = '{use_j: 1'b0, upper: 1'b1};
                3'd4:    p = '{use_j: 1'b0, upper: 1'b0};
                default: p = '{use_j: 1'b1, upper: 1'b1};
            endcase
        end else begin
            // (kL, jL, kU) then (jU, kU, jL)
            case (s)
                3'd0:    p = '{use_j: 1'b0, upper: 1'b0};
                3'd1:    p = '{use_j: 1'b1, upper: 1'b0};
                3'd2:    p = '{use_j: 1'b0, upper: 1'b1};
                3'd3:    p = '{use_j: 1'b1, upper: 1'b1};
                3'd4:    p = '{use_j: 1'b0, upper: 1'b1};
                default: p = '{use_j: 1'b1, upper: 1'b0};
            endcase
        end
        return p;
    endfunction

    assign load         = i_pop_valid && (!r_out_valid || i_out_ready);
    assign o_pop_ready  = load && (r_corner == LAST_CORNER);
    assign o_out_valid  = r_out_valid;
    assign o_out_vertex = r_vtx;

    // Select the current vertex
    always_comb begin
        pick = pick_corner(r_corner, i_pop_edge.swap, i_pop_edge.inner);
        case ({pick.use_j, pick.upper})
            2'b00:   src = i_pop_edge.kl;
            2'b01:   src = i_pop_edge.ku;
            2'b10:   src = i_pop_edge.jl;
            default: src = i_pop_edge.ju;
        endcase
        vtx.vertex_x = src.x;
        vtx.vertex_y = src.y;
        vtx.vertex_z = pick.upper ? i_cfg.z_upper : i_cfg.z_lower;
        vtx.corner   = r_corner;
        vtx.last     = r_corner == LAST_CORNER;
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_vtx <= vtx;
        end
    end

    // Corner counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_corner    <= (r_corner == LAST_CORNER) ? '0 : r_corner + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_corner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_corner <= LAST_CORNER)
        else $error("corner counter out of range");

    // Mid-run, the edge record must still be at the queue head
    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_corner != '0) |-> i_pop_valid)
        else $error("edge left queue before its run ended");

    // Popping an edge puts its closing vertex in the output register
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop_ready |=> (o_out_valid && o_out_vertex.last
                         && o_out_vertex.corner == LAST_CORNER))
        else $error("edge popped without closing vertex");

endmodule

FILE: design/extrude_wall_triangulator.sv
// Extrude wall triangulator top level: configuration registers, front end,
// edge queue, vertex emitter. Uses ewt_pkg, ewt_front, ewt_queue, ewt_back.
// Throughput is set both by the front sequencer (an accept state and five
// steps on a bank of four multipliers, held in the last step while the queue
// is full) and by the six vertices an edge sends through the output register;
// a path-start point returns to idle after its upper rotation and emits nothing.
// Reset (synchronous, active low) restores register defaults, clears the
// previous-point flag, the queue and the output valid; no clearing pass.
module extrude_wall_triangulator
    import ewt_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_point                i_in_point,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_vertex               o_out_vertex,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  push_valid, push_ready, pop_valid, pop_ready;
    t_edge push_edge, pop_edge;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_lower <= TRIG_ONE;
            r_cfg.sin_lower <= TRIG_ZERO;
            r_cfg.cos_upper <= TRIG_ONE;
            r_cfg.sin_upper <= TRIG_ZERO;
            r_cfg.z_lower   <= Z_LOWER_RESET;
            r_cfg.z_upper   <= Z_UPPER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_COS_LOWER: r_cfg.cos_lower <= i_cfg_data[TRIG_W-1:0];
                CFG_SIN_LOWER: r_cfg.sin_lower <= i_cfg_data[TRIG_W-1:0];
                CFG_COS_UPPER: r_cfg.cos_upper <= i_cfg_data[TRIG_W-1:0];
                CFG_SIN_UPPER: r_cfg.sin_upper <= i_cfg_data[TRIG_W-1:0];
                CFG_Z_LOWER:   r_cfg.z_lower   <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_Z_UPPER:   r_cfg.z_upper   <= i_cfg_data[COORD_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    ewt_front #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_point   (i_in_point),
        .i_cfg        (r_cfg),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_edge  (push_edge)
    );

    ewt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_edge  (push_edge),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_edge   (pop_edge)
    );

    ewt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (pop_valid),
        .o_pop_ready  (pop_ready),
        .i_pop_edge   (pop_edge),
        .i_cfg        (r_cfg),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_vertex (o_out_vertex)
    );

endmodule

FILE: test/extrude_wall_triangulator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for extrude_wall_triangulator: rotates each point in a local model,
// builds the six expected wall vertices per edge and checks every output transaction in order.
// Depends on ewt_pkg and the design files only.
module extrude_wall_triangulator_tb;
    import ewt_pkg::*;

    localparam int     FRAC         = 14;
    localparam int     IDLE_PCT     = 19;
    localparam int     HOLD_CYCLES  = 200;
    localparam int     SETTLE       = 20;
    localparam int     STALL_LIMIT  = 5000;
    localparam int     MAX_REPORTS  = 10;
    localparam longint COORD_MAX    = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN    = -COORD_MAX - 1;
    localparam longint HALF_LSB     = longint'(1) <<< (FRAC - 1);
    localparam int     TRIG_MAX     = 16384;

    // Indexes past the register list; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // Quad corner picks: bit 1 = current point, bit 0 = upper copy
    typedef enum logic [1:0] {
        PICK_KL = 2'b00,
        PICK_KU = 2'b01,
        PICK_JL = 2'b10,
        PICK_JU = 2'b11
    } t_pick;

    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    in_valid   = 1'b0;
    t_point  in_point   = '0;
    logic    out_ready  = 1'b0;
    logic    cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic    o_in_ready;
    logic    o_out_valid;
    t_vertex o_out_vertex;
    logic    o_cfg_ready;

    // Model state
    t_cfg    cfg_model;
    t_xy     prev_lo;
    t_xy     prev_up;
    bit      have_prev;
    t_vertex wall_vertices_q[$];

    // Run control and bookkeeping
    bit      no_idle   = 1'b0;
    bit      hold_req  = 1'b0;
    int      hold_left = 0;
    int      stall_cycles = 0;
    int      errors    = 0;
    int      points_sent = 0;
    int      path_starts = 0;
    int      vertices_seen = 0;
    int      reg_writes = 0;
    int      short_diag = 0;
    int      long_diag  = 0;
    t_vertex want;

    extrude_wall_triangulator uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_point   (in_point),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_out_vertex (o_out_vertex),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    // Round half up, then clamp to the coordinate range
    function automatic t_coord round_sat(input longint acc);
        longint r;
        r = (acc + HALF_LSB) >>> FRAC;
        if (r > COORD_MAX) r = COORD_MAX;
        else if (r < COORD_MIN) r = COORD_MIN;
        return t_coord'(r);
    endfunction

    function automatic t_xy turn(input t_coord x, input t_coord y, input t_trig c,
                                 input t_trig s);
        t_xy r;
        r.x = round_sat(longint'(x) * longint'(c) + longint'(y) * longint'(s));
        r.y = round_sat(longint'(y) * longint'(c) - longint'(x) * longint'(s));
        return r;
    endfunction

    // Exact: coordinate differences stay under 2^25, so squares fit easily
    function automatic longint sq_len(input t_xy a, input t_xy b);
        longint dx, dy;
        dx = longint'(a.x) - longint'(b.x);
        dy = longint'(a.y) - longint'(b.y);
        return dx * dx + dy * dy;
    endfunction

    // Vertex order of the two triangles for each diagonal choice
    function automatic t_pick corner_pick(input bit swap, input int src);
        if (swap) begin
            case (src)
                0: return PICK_KL;
                1: return PICK_JL;
                2: return PICK_JU;
                3: return PICK_KU;
                4: return PICK_KL;
                default: return PICK_JU;
            endcase
        end else begin
            case (src)
                0: return PICK_KL;
                1: return PICK_JL;
                2: return PICK_KU;
                3: return PICK_JU;
                4: return PICK_KU;
                default: return PICK_JL;
            endcase
        end
    endfunction

    // Rotate an accepted point and queue the wall vertices of its edge
    task automatic build_wall(input t_point p);
        t_xy     jl, ju, sel;
        bit      swap;
        int      src;
        t_pick   pick;
        t_vertex v;
        jl = turn(p.point_x, p.point_y, cfg_model.cos_lower, cfg_model.sin_lower);
        ju = turn(p.point_x, p.point_y, cfg_model.cos_upper, cfg_model.sin_upper);
        if (p.path_start || !have_prev) begin
            path_starts++;
        end else begin
            swap = sq_len(jl, prev_up) > sq_len(ju, prev_lo);
            if (swap) long_diag++;
            else short_diag++;
            for (int t = 0; t < 6; t++) begin
                // outer paths walk each triangle backwards
                src  = p.hole ? t : (t - t % 3) + (2 - t % 3);
                pick = corner_pick(swap, src);
                case (pick)
                    PICK_KL: sel = prev_lo;
                    PICK_KU: sel = prev_up;
                    PICK_JL: sel = jl;
                    default: sel = ju;
                endcase
                v.vertex_x = sel.x;
                v.vertex_y = sel.y;
                v.vertex_z = pick[0] ? cfg_model.z_upper : cfg_model.z_lower;
                v.corner   = t_corner'(t);
                v.last     = (t_corner'(t) == LAST_CORNER);
                wall_vertices_q.push_back(v);
            end
        end
        prev_lo   = jl;
        prev_up   = ju;
        have_prev = 1'b1;
    endtask

    // ---------------------------------------------------------------- checking

    task automatic note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Every output transaction is compared with the oldest queued vertex
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            vertices_seen++;
            if (wall_vertices_q.size() == 0) begin
                note_error($sformatf("unexpected vertex x=%0d y=%0d z=%0d c=%0d l=%0b",
                           o_out_vertex.vertex_x, o_out_vertex.vertex_y,
                           o_out_vertex.vertex_z, o_out_vertex.corner, o_out_vertex.last));
            end else begin
                want = wall_vertices_q.pop_front();
                if (o_out_vertex.vertex_x !== want.vertex_x ||
                    o_out_vertex.vertex_y !== want.vertex_y ||
                    o_out_vertex.vertex_z !== want.vertex_z ||
                    o_out_vertex.corner   !== want.corner ||
                    o_out_vertex.last     !== want.last) begin
                    note_error($sformatf(
                        "mismatch: exp %0d/%0d/%0d c%0d l%0b, got %0d/%0d/%0d c%0d l%0b",
                        want.vertex_x, want.vertex_y, want.vertex_z, want.corner, want.last,
                        o_out_vertex.vertex_x, o_out_vertex.vertex_y, o_out_vertex.vertex_z,
                        o_out_vertex.corner, o_out_vertex.last));
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: too long without any transaction ends the run
    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d vertices pending",
                     stall_cycles, wall_vertices_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers

    // Called and returns at a falling edge
    task automatic send_point(input t_point p);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_point <= p;
        do @(posedge clk); while (!o_in_ready);
        build_wall(p);
        points_sent++;
        @(negedge clk);
    endtask

    // Wait until every queued vertex has come out and the pipe has settled
    task automatic drain;
        in_valid <= 1'b0;
        while (wall_vertices_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        case (idx)
            CFG_COS_LOWER: cfg_model.cos_lower = t_trig'(data[TRIG_W-1:0]);
            CFG_SIN_LOWER: cfg_model.sin_lower = t_trig'(data[TRIG_W-1:0]);
            CFG_COS_UPPER: cfg_model.cos_upper = t_trig'(data[TRIG_W-1:0]);
            CFG_SIN_UPPER: cfg_model.sin_upper = t_trig'(data[TRIG_W-1:0]);
            CFG_Z_LOWER:   cfg_model.z_lower   = t_coord'(data);
            CFG_Z_UPPER:   cfg_model.z_upper   = t_coord'(data);
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Trig registers take the low 16 bits; the top bits are junk on purpose
    function automatic logic [CFG_DATA_W-1:0] trig_word(input int v);
        return {8'($urandom), 16'(v)};
    endfunction

    task automatic load_config(input int cl, input int sl, input int cu, input int su,
                               input int zl, input int zu);
        drain();
        write_reg(CFG_COS_LOWER, trig_word(cl));
        write_reg(CFG_SIN_LOWER, trig_word(sl));
        write_reg(CFG_COS_UPPER, trig_word(cu));
        write_reg(CFG_SIN_UPPER, trig_word(su));
        write_reg(CFG_Z_LOWER, 24'(zl));
        write_reg(CFG_Z_UPPER, 24'(zu));
    endtask

    function automatic t_point mk_point(input longint x, input longint y, input bit inner,
                                        input bit start);
        t_point p;
        p.point_x    = t_coord'(x);
        p.point_y    = t_coord'(y);
        p.hole       = inner;
        p.path_start = start;
        return p;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 3))
            0: return t_coord'($urandom);
            1: return $urandom_range(0, 1) ? t_coord'(COORD_MAX - $urandom_range(0, 1023))
                                           : t_coord'(COORD_MIN + $urandom_range(0, 1023));
            default: return t_coord'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
        endcase
    endfunction

    function automatic int rand_trig();
        case ($urandom_range(0, 7))
            0: return TRIG_MAX;
            1: return -TRIG_MAX;
            2: return 0;
            default: return int'($urandom_range(0, 2 * TRIG_MAX)) - TRIG_MAX;
        endcase
    endfunction

    function automatic int rand_z();
        if ($urandom_range(0, 3) == 0) return int'(t_coord'($urandom));
        return int'($urandom_range(0, 1 << 14)) - (1 << 13);
    endfunction

    // One closed path; noisy paths occasionally flip the hole flag or the start marker
    task automatic send_path(input int len, input bit noisy);
        t_point p;
        bit     inner;
        inner = $urandom_range(0, 1);
        for (int i = 0; i < len; i++) begin
            p = mk_point(rand_coord(), rand_coord(), inner, i == 0);
            if (noisy && $urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1)) p.hole = ~inner;
                else p.path_start = ~p.path_start;
            end
            send_point(p);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Reset register values; first point after reset acts as a path start
    task automatic test_reset_defaults;
        send_point(mk_point(0, 0, 1'b1, 1'b0));
        send_point(mk_point(256, 0, 1'b1, 1'b0));
        send_point(mk_point(256, 256, 1'b1, 1'b0));
        send_point(mk_point(0, 256, 1'b0, 1'b0));
        send_point(mk_point(COORD_MAX, COORD_MAX, 1'b0, 1'b1));
        send_point(mk_point(COORD_MIN, COORD_MIN, 1'b0, 1'b0));
        send_point(mk_point(COORD_MAX, COORD_MIN, 1'b1, 1'b0));
        send_point(mk_point(-1, 1, 1'b0, 1'b0));
        send_point(mk_point(COORD_MIN, COORD_MAX, 1'b1, 1'b0));
    endtask

    // Ignored spare-index writes; extreme trig and heights drive rotated coordinates into both rails
    task automatic test_saturation;
        drain();
        write_reg(CFG_SPARE_A, 24'($urandom));
        write_reg(CFG_SPARE_B, 24'($urandom));
        load_config(TRIG_MAX, TRIG_MAX, -TRIG_MAX, -TRIG_MAX,
                    int'(COORD_MIN), int'(COORD_MAX));
        send_point(mk_point(COORD_MAX, COORD_MAX, 1'b0, 1'b1));
        send_point(mk_point(COORD_MIN, COORD_MIN, 1'b0, 1'b0));
        send_point(mk_point(COORD_MAX, COORD_MIN, 1'b0, 1'b0));
        send_point(mk_point(COORD_MIN, COORD_MAX, 1'b0, 1'b0));
        load_config(-TRIG_MAX, TRIG_MAX, TRIG_MAX, -TRIG_MAX,
                    int'(COORD_MAX), int'(COORD_MIN));
        send_point(mk_point(COORD_MAX, 0, 1'b1, 1'b1));
        send_point(mk_point(0, COORD_MIN, 1'b1, 1'b0));
        send_point(mk_point(COORD_MIN, COORD_MIN, 1'b1, 1'b0));
        send_point(mk_point(COORD_MAX, COORD_MAX, 1'b1, 1'b0));
    endtask

    // Half-LSB rounding, and a register change in the middle of a path
    task automatic test_midpath_config;
        load_config(TRIG_MAX / 2, 0, -TRIG_MAX / 2, 0, -256, 512);
        send_point(mk_point(1, -1, 1'b0, 1'b1));
        send_point(mk_point(-1, 1, 1'b0, 1'b0));
        send_point(mk_point(3, -3, 1'b1, 1'b0));
        load_config(0, TRIG_MAX, 11585, 11585, 1000, -1000);
        send_point(mk_point(700, -300, 1'b1, 1'b0));
        send_point(mk_point(-5000, 9000, 1'b0, 1'b0));
    endtask

    task automatic test_random_paths(input int n_points, input bit steady);
        int sent;
        int len;
        sent = 0;
        load_config(rand_trig(), rand_trig(), rand_trig(), rand_trig(), rand_z(), rand_z());
        no_idle = steady;
        while (sent < n_points) begin
            len = $urandom_range(2, 10);
            send_path(len, 1'b1);
            sent += len;
        end
        no_idle = 1'b0;
    endtask

    // Receiver holds off while the sender keeps pushing; input must stall
    task automatic test_backpressure;
        load_config(rand_trig(), rand_trig(), rand_trig(), rand_trig(), rand_z(), rand_z());
        no_idle  = 1'b1;
        hold_req = 1'b1;
        send_path(24, 1'b0);
        no_idle  = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        cfg_model = '{TRIG_ONE, TRIG_ZERO, TRIG_ONE, TRIG_ZERO, Z_LOWER_RESET, Z_UPPER_RESET};
        prev_lo   = '0;
        prev_up   = '0;
        have_prev = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_saturation();
        test_midpath_config();
        test_random_paths(115, 1'b0);
        test_random_paths(115, 1'b1);
        test_backpressure();
        test_random_paths(115, 1'b0);
        test_random_paths(115, 1'b0);
        drain();

        $display("Run covered %0d points (%0d path starts) and %0d register writes;",
                 points_sent, path_starts, reg_writes);
        $display("%0d vertices checked, diagonal split %0d short / %0d long, %0d errors.",
                 vertices_seen, short_diag, long_diag, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
